/* hw/rtl/frp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// frp_pkg
// Shared constants, event codes and the nibble-table CRC-16 step.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int unsigned LocalTypes  = 16;
  localparam int unsigned TypeW       = 4;
  localparam int unsigned HeaderBytes = 14;

  // Event codes on the result channel
  localparam logic [3:0] EV_NONE       = 4'd0;
  localparam logic [3:0] EV_HDR_OK     = 4'd1;
  localparam logic [3:0] EV_HDR_BAD    = 4'd2;
  localparam logic [3:0] EV_VALUE_A    = 4'd3;
  localparam logic [3:0] EV_VALUE_B    = 4'd4;
  localparam logic [3:0] EV_FILE_OK    = 4'd5;
  localparam logic [3:0] EV_FILE_BAD   = 4'd6;
  localparam logic [3:0] EV_BAD_RECORD = 4'd7;
  localparam logic [3:0] EV_TOO_MANY   = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] CFG_A_MSG = 3'd0;
  localparam logic [2:0] CFG_A_FLD = 3'd1;
  localparam logic [2:0] CFG_B_MSG = 3'd2;
  localparam logic [2:0] CFG_B_FLD = 3'd3;

  // Record header codes (upper nibble)
  localparam logic [3:0] REC_DATA = 4'h0;
  localparam logic [3:0] REC_DEF  = 4'h4;

  function automatic logic [15:0] nib_tab(input logic [3:0] n);
    logic [15:0] r;
    begin
      case (n)
        4'h0: r = 16'h0000;
        4'h1: r = 16'hCC01;
        4'h2: r = 16'hD801;
        4'h3: r = 16'h1400;
        4'h4: r = 16'hF001;
        4'h5: r = 16'h3C00;
        4'h6: r = 16'h2800;
        4'h7: r = 16'hE401;
        4'h8: r = 16'hA001;
        4'h9: r = 16'h6C00;
        4'hA: r = 16'h7800;
        4'hB: r = 16'hB401;
        4'hC: r = 16'h5000;
        4'hD: r = 16'h9C01;
        4'hE: r = 16'h8801;
        default: r = 16'h4400;
      endcase
      return r;
    end
  endfunction

  // One byte of the reflected 0xA001 CRC, low nibble first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] t;
    logic [15:0] c1;
    begin
      t  = nib_tab(c[3:0]);
      c1 = {4'h0, c[15:4]} ^ t ^ nib_tab(b[3:0]);
      t  = nib_tab(c1[3:0]);
      return {4'h0, c1[15:4]} ^ t ^ nib_tab(b[7:4]);
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/frp_fld_tbl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// frp_fld_tbl
// Field definition memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module frp_fld_tbl #(
  parameter int unsigned AW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [15:0]   rdata_o
);

  logic [15:0] mem_q [2**AW];

  // entry = field number << 8 | field size
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fit_record_stream_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fit_record_stream_parser_top
// FIT stream parser: header CRC, definition/data records, two field captures
// and the trailing data CRC.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  input   | in        | in_valid_i / in_stall_o  | data_byte_i[7:0]
//  result  | out       | out_valid_o / out_stall_i| event_res_o[3:0], value_o[31:0]
//  config  | in        | cfg_we_i                 | cfg_idx_i[2:0], cfg_data_i[15:0]
//
// One byte per cycle in header, record header, definition and field bytes,
// unless a held result stalls the input. Before each data field the field
// memory is walked: each field entry looked at is read in PH_SCAN, then
// checked in PH_LOOK, and PH_SCAN closes the record; the input is stalled
// meanwhile. One result per byte, shown in the cycle after the transfer;
// a held result stalls the next byte. Reset clears all control state; halted
// after an error until reset.
// ----------------------------------------------------------------------------
module fit_record_stream_parser_top #(
  parameter int unsigned MAX_FIELDS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       event_res_o,
  output logic [31:0]      value_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_FIELDS + 1);
  localparam int unsigned IW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int unsigned AW = frp_pkg::TypeW + IW;

  typedef enum logic [3:0] {
    PH_HEADER, PH_RECHDR, PH_DEFFIX, PH_DEFFLD, PH_DATA, PH_CRC, PH_HALT,
    PH_SCAN, PH_LOOK
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [3:0]   pos_q, pos_d;
  logic [15:0]  hc_q, hc_d;
  logic [15:0]  dc_q, dc_d;
  logic [7:0]   rx_q, rx_d;
  logic [31:0]  len_q, len_d;
  logic [31:0]  cons_q, cons_d;
  logic [3:0]   type_q, type_d;
  logic [15:0]  pmsg_q, pmsg_d;
  logic [CW-1:0] pcnt_q, pcnt_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [7:0]   bl_q, bl_d;
  logic [7:0]   num_q, num_d;
  logic [31:0]  cap_q, cap_d;
  logic [15:0]  tmsg_q [frp_pkg::LocalTypes];
  logic [CW-1:0] tcnt_q [frp_pkg::LocalTypes];
  logic         tdef_we;
  logic [CW-1:0] tdef_cnt;
  logic         tcnt_clr;

  logic [15:0]  a_msg_q, b_msg_q;
  logic [7:0]   a_fld_q, b_fld_q;

  logic         out_valid_q;
  logic [3:0]   ev_q;
  logic [31:0]  val_q;
  logic [3:0]   ev_d;
  logic [31:0]  val_d;

  logic         acc;
  logic [7:0]   b;
  logic         mem_we, mem_re;
  logic [15:0]  mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0] cur_inc;
  logic [7:0]   bl_new;

  assign b          = data_byte_i;
  assign in_stall_o = (phase_q == PH_SCAN) || (phase_q == PH_LOOK) ||
                      (out_valid_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;
  assign cur_inc    = cur_q + 1'b1;
  assign bl_new     = bl_q - 8'd1;

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign value_o     = val_q;

  assign mem_waddr = {type_q, cur_q[IW-1:0]};
  assign mem_wdata = {num_q, b};
  assign mem_raddr = {type_q, cur_q[IW-1:0]};

  frp_fld_tbl #(.AW(AW)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state of the parser
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    hc_d     = hc_q;
    dc_d     = dc_q;
    rx_d     = rx_q;
    len_d    = len_q;
    cons_d   = cons_q;
    type_d   = type_q;
    pmsg_d   = pmsg_q;
    pcnt_d   = pcnt_q;
    cur_d    = cur_q;
    bl_d     = bl_q;
    num_d    = num_q;
    cap_d    = cap_q;
    ev_d     = frp_pkg::EV_NONE;
    val_d    = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    tdef_we  = 1'b0;
    tdef_cnt = '0;
    tcnt_clr = 1'b0;

    // record bytes feed the data CRC and the byte count
    if (acc && (phase_q == PH_RECHDR || phase_q == PH_DEFFIX ||
                phase_q == PH_DEFFLD || phase_q == PH_DATA)) begin
      dc_d = frp_pkg::crc_byte(dc_q, b);
      if (cons_q != '1) begin
        cons_d = cons_q + 32'd1;
      end
    end

    case (phase_q)
      PH_HEADER: begin
        if (acc) begin
          if (pos_q == 4'd0) begin
            hc_d  = frp_pkg::crc_byte(16'h0000, b);
            len_d = '0;
          end else if (pos_q < 4'd12) begin
            hc_d = frp_pkg::crc_byte(hc_q, b);
          end
          if (pos_q >= 4'd4 && pos_q < 4'd8) begin
            len_d[8*pos_q[1:0] +: 8] = b;
          end
          if (pos_q == 4'd12) begin
            rx_d = b;
          end
          pos_d = pos_q + 4'd1;
          if (pos_q == 4'(frp_pkg::HeaderBytes - 1)) begin
            pos_d = '0;
            if ({b, rx_q} == hc_q) begin
              ev_d   = frp_pkg::EV_HDR_OK;
              dc_d   = '0;
              cons_d = '0;
              phase_d = (len_q == '0) ? PH_CRC : PH_RECHDR;
            end else begin
              ev_d    = frp_pkg::EV_HDR_BAD;
              phase_d = PH_HALT;
            end
          end
        end
      end
      PH_RECHDR: begin
        if (acc) begin
          type_d = b[3:0];
          if (b[7:4] == frp_pkg::REC_DEF) begin
            phase_d = PH_DEFFIX;
            pos_d   = '0;
          end else if (b[7:4] == frp_pkg::REC_DATA) begin
            cur_d   = '0;
            phase_d = PH_SCAN;
          end else begin
            ev_d    = frp_pkg::EV_BAD_RECORD;
            phase_d = PH_HALT;
          end
        end
      end
      PH_DEFFIX: begin
        if (acc) begin
          if (pos_q == 4'd2) pmsg_d[7:0] = b;
          if (pos_q == 4'd3) pmsg_d[15:8] = b;
          pos_d = pos_q + 4'd1;
          if (pos_q == 4'd4) begin
            if (b > 8'(MAX_FIELDS)) begin
              ev_d    = frp_pkg::EV_TOO_MANY;
              phase_d = PH_HALT;
            end else if (b == 8'd0) begin
              tdef_we  = 1'b1;
              tdef_cnt = '0;
              pos_d    = '0;
              phase_d  = (cons_d >= len_q) ? PH_CRC : PH_RECHDR;
            end else begin
              pcnt_d  = b[CW-1:0];
              cur_d   = '0;
              pos_d   = '0;
              phase_d = PH_DEFFLD;
            end
          end
        end
      end
      PH_DEFFLD: begin
        if (acc) begin
          if (pos_q == 4'd0) num_d = b;
          if (pos_q == 4'd1) mem_we = 1'b1;
          pos_d = pos_q + 4'd1;
          if (pos_q == 4'd2) begin
            pos_d = '0;
            cur_d = cur_inc;
            if (cur_inc >= pcnt_q) begin
              tdef_we  = 1'b1;
              tdef_cnt = pcnt_q;
              phase_d  = (cons_d >= len_q) ? PH_CRC : PH_RECHDR;
            end
          end
        end
      end
      PH_SCAN: begin
        // walk to the next field of nonzero size
        if (cur_q >= tcnt_q[type_q]) begin
          pos_d   = '0;
          phase_d = (cons_q >= len_q) ? PH_CRC : PH_RECHDR;
        end else begin
          mem_re  = 1'b1;
          phase_d = PH_LOOK;
        end
      end
      PH_LOOK: begin
        if (mem_rdata[7:0] == 8'd0) begin
          cur_d   = cur_inc;
          phase_d = PH_SCAN;
        end else begin
          bl_d    = mem_rdata[7:0];
          num_d   = mem_rdata[15:8];
          cap_d   = '0;
          pos_d   = '0;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        if (acc) begin
          if (pos_q < 4'd4) begin
            cap_d[8*pos_q[1:0] +: 8] = b;
            pos_d = pos_q + 4'd1;
          end
          bl_d = bl_new;
          if (bl_new == 8'd0) begin
            if (tmsg_q[type_q] == a_msg_q && num_q == a_fld_q) begin
              ev_d  = frp_pkg::EV_VALUE_A;
              val_d = cap_d;
            end else if (tmsg_q[type_q] == b_msg_q && num_q == b_fld_q) begin
              ev_d  = frp_pkg::EV_VALUE_B;
              val_d = {16'h0000, cap_d[15:0]};
            end
            cur_d   = cur_inc;
            phase_d = PH_SCAN;
          end
        end
      end
      PH_CRC: begin
        if (acc) begin
          if (pos_q == 4'd0) begin
            rx_d  = b;
            pos_d = 4'd1;
          end else begin
            ev_d     = ({b, rx_q} == dc_q) ? frp_pkg::EV_FILE_OK : frp_pkg::EV_FILE_BAD;
            pos_d    = '0;
            phase_d  = PH_HEADER;
            tcnt_clr = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Parser state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      hc_q        <= '0;
      dc_q        <= '0;
      rx_q        <= '0;
      len_q       <= '0;
      cons_q      <= '0;
      type_q      <= '0;
      pmsg_q      <= '0;
      pcnt_q      <= '0;
      cur_q       <= '0;
      bl_q        <= '0;
      num_q       <= '0;
      cap_q       <= '0;
      out_valid_q <= 1'b0;
      ev_q        <= frp_pkg::EV_NONE;
      val_q       <= '0;
      for (int i = 0; i < frp_pkg::LocalTypes; i++) begin
        tmsg_q[i] <= '0;
        tcnt_q[i] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      hc_q    <= hc_d;
      dc_q    <= dc_d;
      rx_q    <= rx_d;
      len_q   <= len_d;
      cons_q  <= cons_d;
      type_q  <= type_d;
      pmsg_q  <= pmsg_d;
      pcnt_q  <= pcnt_d;
      cur_q   <= cur_d;
      bl_q    <= bl_d;
      num_q   <= num_d;
      cap_q   <= cap_d;
      if (tcnt_clr) begin
        for (int i = 0; i < frp_pkg::LocalTypes; i++) begin
          tcnt_q[i] <= '0;
        end
      end else if (tdef_we) begin
        tmsg_q[type_q] <= pmsg_d;
        tcnt_q[type_q] <= tdef_cnt;
      end
      if (acc) begin
        out_valid_q <= 1'b1;
        ev_q        <= ev_d;
        val_q       <= val_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_msg_q <= 16'd0;
      a_fld_q <= 8'd4;
      b_msg_q <= 16'd19;
      b_fld_q <= 8'd13;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        frp_pkg::CFG_A_MSG: a_msg_q <= cfg_data_i;
        frp_pkg::CFG_A_FLD: a_fld_q <= cfg_data_i[7:0];
        frp_pkg::CFG_B_MSG: b_msg_q <= cfg_data_i;
        frp_pkg::CFG_B_FLD: b_fld_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/frp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// frp_checker
// Port-level checks on the parser, bound to the top level.
// ----------------------------------------------------------------------------
module frp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [3:0]  event_res_o,
  input wire logic [31:0] value_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) && $stable(value_o))
    else $error("result changed while stalled");

  // a value travels only with a capture event
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != frp_pkg::EV_VALUE_A &&
    event_res_o != frp_pkg::EV_VALUE_B |-> value_o == 32'd0)
    else $error("value without capture event");

  // value B is 16 bits wide
  a_value_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == frp_pkg::EV_VALUE_B |-> value_o[31:16] == 16'h0000)
    else $error("value B wider than 16 bits");

  // every new result follows an input transfer
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without input transfer");

endmodule

bind fit_record_stream_parser_top frp_checker u_frp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .event_res_o (event_res_o),
  .value_o     (value_o)
);
`default_nettype wire

/* tb/fit_record_stream_parser_checker.sv */
// ----------------------------------------------------------------------------
// fit_record_stream_parser_checker
// Watches the byte and result channels of the FIT stream parser, predicts
// one result per accepted byte and compares each result field by field.
// ----------------------------------------------------------------------------
module fit_record_stream_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  event_res_i,
  input  logic [31:0] value_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FieldSlots = 64;

  typedef enum logic [2:0] {
    ST_HEADER, ST_REC_HDR, ST_DEF_FIXED, ST_DEF_FIELD, ST_FIELD, ST_TRAILER, ST_HALTED
  } parse_state_e;

  typedef struct packed {
    logic [3:0]  ev;
    logic [31:0] val;
  } parse_result_t;

  parse_result_t expected_results[$];

  // capture registers
  logic [15:0] a_msg, b_msg;
  logic [7:0]  a_fld, b_fld;

  // parser state copy
  parse_state_e st;
  int unsigned  pos, cursor, left, pend_cnt;
  logic [15:0]  hdr_crc, rec_crc, crc_rx, pend_msg;
  logic [31:0]  rec_len, used, capt;
  logic [3:0]   ltype;
  logic [15:0]  type_msg [frp_pkg::LocalTypes];
  int unsigned  type_cnt [frp_pkg::LocalTypes];
  logic [15:0]  fields [frp_pkg::LocalTypes][FieldSlots];

  // bitwise reflected 0xA001 CRC step
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  task automatic close_record();
    if (used >= rec_len) begin
      st = ST_TRAILER;
      pos = 0;
    end else begin
      st = ST_REC_HDR;
    end
  endtask

  // skip zero-size fields, then start the next one or close the record
  task automatic seek_field();
    while (cursor < type_cnt[ltype] && cursor < FieldSlots && fields[ltype][cursor][7:0] == 0)
      cursor++;
    if (cursor >= type_cnt[ltype] || cursor >= FieldSlots) begin
      close_record();
    end else begin
      left = fields[ltype][cursor][7:0];
      capt = '0;
      pos  = 0;
      st   = ST_FIELD;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, output parse_result_t r);
    logic [7:0] num;
    r = '{ev: frp_pkg::EV_NONE, val: '0};
    if (st != ST_HEADER && st != ST_TRAILER && st != ST_HALTED) begin
      rec_crc = crc_step(rec_crc, b);
      if (used != 32'hFFFF_FFFF) used++;
    end
    case (st)
      ST_HEADER: begin
        if (pos == 0) begin
          hdr_crc = '0;
          rec_len = '0;
        end
        if (pos < 12) hdr_crc = crc_step(hdr_crc, b);
        if (pos >= 4 && pos < 8) rec_len |= 32'(b) << (8 * (pos - 4));
        if (pos == 12) crc_rx = {8'h00, b};
        pos++;
        if (pos >= frp_pkg::HeaderBytes) begin
          crc_rx[15:8] = b;
          pos = 0;
          if (crc_rx == hdr_crc) begin
            r.ev = frp_pkg::EV_HDR_OK;
            rec_crc = '0;
            used = '0;
            st = (rec_len == 0) ? ST_TRAILER : ST_REC_HDR;
          end else begin
            r.ev = frp_pkg::EV_HDR_BAD;
            st = ST_HALTED;
          end
        end
      end
      ST_REC_HDR: begin
        ltype = b[3:0];
        if (b[7:4] == frp_pkg::REC_DEF) begin
          st = ST_DEF_FIXED;
          pos = 0;
        end else if (b[7:4] == frp_pkg::REC_DATA) begin
          cursor = 0;
          seek_field();
        end else begin
          r.ev = frp_pkg::EV_BAD_RECORD;
          st = ST_HALTED;
        end
      end
      ST_DEF_FIXED: begin
        if (pos == 2) pend_msg = {8'h00, b};
        else if (pos == 3) pend_msg[15:8] = b;
        pos++;
        if (pos == 5) begin
          pend_cnt = b;
          if (b > FieldSlots) begin
            r.ev = frp_pkg::EV_TOO_MANY;
            st = ST_HALTED;
          end else if (b == 0) begin
            type_msg[ltype] = pend_msg;
            type_cnt[ltype] = 0;
            close_record();
          end else begin
            cursor = 0;
            pos = 0;
            st = ST_DEF_FIELD;
          end
        end
      end
      ST_DEF_FIELD: begin
        if (cursor < FieldSlots) begin
          if (pos == 0) fields[ltype][cursor][15:8] = b;
          else if (pos == 1) fields[ltype][cursor][7:0] = b;
        end
        pos++;
        if (pos == 3) begin
          pos = 0;
          cursor++;
          if (cursor >= pend_cnt) begin
            type_msg[ltype] = pend_msg;
            type_cnt[ltype] = pend_cnt;
            close_record();
          end
        end
      end
      ST_FIELD: begin
        if (pos < 4) begin
          capt |= 32'(b) << (8 * pos);
          pos++;
        end
        if (left > 0) left--;
        if (left == 0) begin
          num = (cursor < FieldSlots) ? fields[ltype][cursor][15:8] : 8'h00;
          if (type_msg[ltype] == a_msg && num == a_fld) begin
            r.ev = frp_pkg::EV_VALUE_A;
            r.val = capt;
          end else if (type_msg[ltype] == b_msg && num == b_fld) begin
            r.ev = frp_pkg::EV_VALUE_B;
            r.val = {16'h0000, capt[15:0]};
          end
          cursor++;
          seek_field();
        end
      end
      ST_TRAILER: begin
        if (pos == 0) begin
          crc_rx = {8'h00, b};
          pos = 1;
        end else begin
          crc_rx[15:8] = b;
          r.ev = (crc_rx == rec_crc) ? frp_pkg::EV_FILE_OK : frp_pkg::EV_FILE_BAD;
          pos = 0;
          st = ST_HEADER;
          foreach (type_cnt[t]) type_cnt[t] = 0;
        end
      end
      default: ;
    endcase
  endtask

  assign waiting_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t exp_r;
    parse_result_t got;
    if (!rst_ni) begin
      a_msg = 16'd0; a_fld = 8'd4; b_msg = 16'd19; b_fld = 8'd13;
      st = ST_HEADER; pos = 0; cursor = 0; left = 0; pend_cnt = 0;
      hdr_crc = '0; rec_crc = '0; crc_rx = '0; pend_msg = '0;
      rec_len = '0; used = '0; capt = '0; ltype = '0;
      foreach (type_msg[t]) begin
        type_msg[t] = '0;
        type_cnt[t] = 0;
        foreach (fields[t][f]) fields[t][f] = '0;
      end
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          frp_pkg::CFG_A_MSG: a_msg = cfg_data_i;
          frp_pkg::CFG_A_FLD: a_fld = cfg_data_i[7:0];
          frp_pkg::CFG_B_MSG: b_msg = cfg_data_i;
          frp_pkg::CFG_B_FLD: b_fld = cfg_data_i[7:0];
          default: ;
        endcase
      end
      // byte transfer: predict first, in case its result leaves this edge
      if (in_valid_i && !in_stall_i) begin
        parse_byte(data_byte_i, exp_r);
        expected_results.push_back(exp_r);
      end
      // result transfer
      if (out_valid_i && !out_stall_i) begin
        got = '{ev: event_res_i, val: value_i};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result ev=%0d value=%h", $realtime, got.ev, got.val);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.ev !== exp_r.ev) begin
            $display("%0t: event_res expected %0d actual %0d", $realtime, exp_r.ev, got.ev);
            fail_count_o++;
          end
          if (got.val !== exp_r.val) begin
            $display("%0t: value expected %h actual %h", $realtime, exp_r.val, got.val);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

/* tb/fit_record_stream_parser_top_tb.sv */
// ----------------------------------------------------------------------------
// fit_record_stream_parser_top_tb
// Feeds generated FIT files (good, bad trailer, empty, and one fatal error at
// the end) through the parser under several capture settings with random
// idling on both channels; a checker module predicts and compares results.
// ----------------------------------------------------------------------------
module fit_record_stream_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TargetBytes = 1200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  event_res_o;
  logic [31:0] value_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  int  fail_count, waiting;
  bit  steady;          // no idling on either side
  int  bytes_sent, files_sent, settings_used;

  // generator's view of the capture registers and the definitions in a file
  logic [15:0] a_msg = 16'd0, b_msg = 16'd19;
  logic [7:0]  a_fld = 8'd4, b_fld = 8'd13;
  logic [7:0]  def_size [16][$];
  bit          def_done [16];
  logic [7:0]  rec_bytes[$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  fit_record_stream_parser_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i,
    .out_valid_o, .out_stall_i, .event_res_o, .value_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  fit_record_stream_parser_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .data_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .event_res_i(event_res_o), .value_i(value_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .waiting_o(waiting)
  );

  // receiver stalls
  always @(posedge clk_i) out_stall_i <= steady ? 1'b0 : ($urandom_range(99) < 12);

  function automatic logic [15:0] crc_of(input logic [15:0] c, input logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // hold the sender until the result queue drains
  task automatic drain();
    in_valid_i <= 1'b0;
    while (waiting != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capture(input logic [15:0] am, input logic [7:0] af,
                             input logic [15:0] bm, input logic [7:0] bf);
    drain();
    a_msg = am; a_fld = af; b_msg = bm; b_fld = bf;
    cfg_we_i <= 1'b1; cfg_idx_i <= frp_pkg::CFG_A_MSG; cfg_data_i <= am; @(posedge clk_i);
    cfg_idx_i <= frp_pkg::CFG_A_FLD; cfg_data_i <= {8'h00, af};        @(posedge clk_i);
    cfg_idx_i <= frp_pkg::CFG_B_MSG; cfg_data_i <= bm;                 @(posedge clk_i);
    cfg_idx_i <= frp_pkg::CFG_B_FLD; cfg_data_i <= {8'h00, bf};        @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  function automatic logic [15:0] pick_msg();
    case ($urandom_range(3))
      0: return a_msg;
      1: return b_msg;
      2: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_fld();
    case ($urandom_range(3))
      0: return a_fld;
      1: return b_fld;
      default: return 8'($urandom);
    endcase
  endfunction

  // append one definition or data record to rec_bytes
  task automatic add_record();
    int lt, cnt, sz;
    logic [15:0] m;
    lt = $urandom_range(15);
    if ($urandom_range(2) == 0 || !def_done[lt]) begin
      if ($urandom_range(4) == 0) begin
        // data record of a type that may not be defined in this file
        rec_bytes.push_back({frp_pkg::REC_DATA, 4'(lt)});
        foreach (def_size[lt][i])
          for (int k = 0; k < def_size[lt][i]; k++) rec_bytes.push_back(8'($urandom));
        return;
      end
      m = pick_msg();
      case ($urandom_range(19))
        0: cnt = 0;
        1: cnt = 64;
        default: cnt = $urandom_range(1, 6);
      endcase
      rec_bytes.push_back({frp_pkg::REC_DEF, 4'(lt)});
      rec_bytes.push_back(8'($urandom));
      rec_bytes.push_back(8'($urandom));
      rec_bytes.push_back(m[7:0]);
      rec_bytes.push_back(m[15:8]);
      rec_bytes.push_back(8'(cnt));
      def_size[lt].delete();
      for (int i = 0; i < cnt; i++) begin
        sz = ($urandom_range(49) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 6);
        rec_bytes.push_back(pick_fld());
        rec_bytes.push_back(8'(sz));
        rec_bytes.push_back(8'($urandom));
        def_size[lt].push_back(8'(sz));
      end
      def_done[lt] = 1'b1;
    end else begin
      rec_bytes.push_back({frp_pkg::REC_DATA, 4'(lt)});
      foreach (def_size[lt][i])
        for (int k = 0; k < def_size[lt][i]; k++) rec_bytes.push_back(8'($urandom));
    end
  endtask

  // fatal: 0 none, 1 bad header CRC, 2 unsupported record, 3 too many fields
  task automatic send_file(input int nrec, input bit bad_trailer, input int fatal);
    logic [7:0]  hdr[14];
    logic [15:0] c;
    logic [31:0] len;
    rec_bytes.delete();
    foreach (def_done[t]) begin
      def_done[t] = 1'b0;
      def_size[t].delete();
    end
    for (int i = 0; i < nrec; i++) add_record();
    if (fatal == 2) rec_bytes.push_back({4'($urandom_range(5, 15)), 4'($urandom)});
    if (fatal == 3) begin
      rec_bytes.push_back({frp_pkg::REC_DEF, 4'($urandom)});
      repeat (4) rec_bytes.push_back(8'($urandom));
      rec_bytes.push_back(8'($urandom_range(65, 255)));
    end
    len = (fatal >= 2) ? 32'(rec_bytes.size()) + 32'($urandom_range(1, 1000))
                       : 32'(rec_bytes.size());
    hdr[0] = 8'd14; hdr[1] = 8'($urandom); hdr[2] = 8'($urandom); hdr[3] = 8'($urandom);
    {hdr[7], hdr[6], hdr[5], hdr[4]} = len;
    hdr[8] = ".";  hdr[9] = "F";  hdr[10] = "I";  hdr[11] = "T";
    c = '0;
    for (int i = 0; i < 12; i++) c = crc_of(c, hdr[i]);
    if (fatal == 1) c ^= 16'(1 << $urandom_range(15));
    {hdr[13], hdr[12]} = c;
    foreach (hdr[i]) send_byte(hdr[i]);
    if (fatal == 1) return;
    c = '0;
    foreach (rec_bytes[i]) begin
      send_byte(rec_bytes[i]);
      c = crc_of(c, rec_bytes[i]);
    end
    if (fatal != 0) return;
    if (bad_trailer) c ^= 16'(1 << $urandom_range(15));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    files_sent++;
  endtask

  initial begin
    int phase_bytes;
    steady = 1'b0;
    bytes_sent = 0; files_sent = 0; settings_used = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty good and bad files, short files at reset and all-ones capture
    send_file(0, 1'b0, 0);
    send_file(0, 1'b1, 0);
    send_file(2, 1'b0, 0);
    set_capture(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);   // both pairs equal: A wins
    send_file(3, 1'b0, 0);

    // random files under changing capture settings; the first stretch never idles
    while (bytes_sent < TargetBytes) begin
      case (settings_used % 4)
        0: set_capture(16'($urandom_range(3)), 8'($urandom), 16'($urandom_range(3)),
                       8'($urandom));
        1: set_capture(16'h0000, 8'h00, 16'hFFFF, 8'hFF);
        2: set_capture(16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        default: set_capture(16'($urandom_range(1)), 8'($urandom_range(1)),
                             16'($urandom_range(1)), 8'($urandom_range(1)));
      endcase
      steady = (settings_used == 2) || ($urandom_range(4) == 0);
      phase_bytes = bytes_sent;
      while (bytes_sent - phase_bytes < 250 && bytes_sent < TargetBytes)
        send_file($urandom_range(1, 12), $urandom_range(5) == 0, 0);
      steady = 1'b0;
    end

    // a fatal error last, since only a reset recovers; then ignored bytes
    send_file($urandom_range(0, 4), 1'b0, $urandom_range(1, 3));
    repeat (10) send_byte(8'($urandom));
    in_valid_i <= 1'b0;

    while (waiting != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("sent %0d bytes in %0d complete files over %0d capture settings,",
             bytes_sent, files_sent, settings_used);
    $display("ending with one fatal stream error and ignored bytes");
    if (fail_count == 0) $display("fit_record_stream_parser_top_tb: done, clean");
    else $display("fit_record_stream_parser_top_tb: done, errors");
    $finish;
  end

  initial begin
    #10ms;
    $display("fit_record_stream_parser_top_tb: done, errors");
    $finish;
  end

endmodule
